// ===== hw/rtl/rpp_pkg.sv =====
// ----------------------------------------------------------------------------
// rpp_pkg: shared types and constants for the polyline rotate/project block
// Fixed coordinate format, screen limits, register indexes and the input
// and result word types.
// ----------------------------------------------------------------------------
package rpp_pkg;

  localparam int COORD_WIDTH     = 16;   // Q8.8 vertex coordinates
  localparam int COORD_FRAC_BITS = 8;
  localparam int FOCAL           = 350;
  localparam int CENTER_WIDTH    = 12;
  localparam int SCREEN_WIDTH    = 16;
  localparam int QUOT_BITS       = 16;   // quotient bits produced per divide

  localparam logic signed [SCREEN_WIDTH-1:0] SCREEN_MAX = 16'sh7FFF;
  localparam logic signed [SCREEN_WIDTH-1:0] SCREEN_MIN = 16'sh8000;

  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COS_X    = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SIN_X    = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COS_Y    = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SIN_Y    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COS_Z    = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SIN_Z    = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_X = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_Y = 3'd7;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vx;
    logic signed [COORD_WIDTH-1:0] vy;
    logic signed [COORD_WIDTH-1:0] vz;
    logic                          first_point;
  } in_item_t;

  typedef struct packed {
    logic signed [SCREEN_WIDTH-1:0] from_x;
    logic signed [SCREEN_WIDTH-1:0] from_y;
    logic signed [SCREEN_WIDTH-1:0] to_x;
    logic signed [SCREEN_WIDTH-1:0] to_y;
  } out_item_t;

endpackage

// ===== hw/rtl/rotate_project_polyline.sv =====
// Sequence: after input acceptance, rotation multiply-accumulate passes (X, Y,
//   Z), a depth step, a projection and divide per screen axis, then a finish step.
// Input: a new vertex is accepted only in idle, once the last one is finished;
//   the pace is set by the single shared multiplier and the 16-step restoring divider.
// Reset: sync active-high; trig registers to identity, center to (450,300),
//   stored last point to (0,0), no result pending.
// ----------------------------------------------------------------------------
// rotate_project_polyline: rotate 3D vertices, project, emit line segments
// One multiplier with an accumulator rotates about X, Y, Z and forms the
// projection numerators; a serial divider divides each by the depth.
// ----------------------------------------------------------------------------
module rotate_project_polyline #(
  parameter int  TRIG_FRAC_BITS = 14,
  localparam int TRIG_WIDTH     = TRIG_FRAC_BITS + 2,
  localparam int CFG_WIDTH      = (TRIG_WIDTH > rpp_pkg::CENTER_WIDTH) ?
                                  TRIG_WIDTH : rpp_pkg::CENTER_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rpp_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rpp_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rpp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]                cfg_data
);

  // rotated coordinates grow at most 2 bits per axis, plus sign headroom
  localparam int RW = rpp_pkg::COORD_WIDTH + 7;
  localparam int AW = RW + 1;
  localparam int BW = (TRIG_WIDTH > rpp_pkg::CENTER_WIDTH + 1) ?
                      TRIG_WIDTH : rpp_pkg::CENTER_WIDTH + 1;
  localparam int PW = AW + BW;
  localparam int NW = PW + 1;
  localparam int DW = AW + BW + 3;
  localparam int SW = rpp_pkg::SCREEN_WIDTH;
  localparam int QB = rpp_pkg::QUOT_BITS;
  localparam int CNT_W = $clog2(QB);
  localparam int FOCAL_Q = rpp_pkg::FOCAL << rpp_pkg::COORD_FRAC_BITS;

  localparam logic signed [NW-1:0] ROUND_HALF = NW'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE =
    {2'b01, {TRIG_FRAC_BITS{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_ZS,
    ST_DIV_PREP,
    ST_DIV,
    ST_DIV_DONE,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_X_NY,
    OP_X_NZ,
    OP_Y_NX,
    OP_Y_NZ,
    OP_Z_NX,
    OP_Z_NY,
    OP_PROJ_X,
    OP_PROJ_Y
  } op_t;

  state_t state;
  op_t    op;

  logic signed [TRIG_WIDTH-1:0] cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;
  logic [rpp_pkg::CENTER_WIDTH-1:0] center_x, center_y;
  logic signed [SW-1:0] last_x, last_y;

  logic signed [RW-1:0] x, y, z, tmp;
  logic [AW-1:0]        zs;
  logic                 first;
  logic signed [PW-1:0] p;
  logic signed [NW-1:0] acc;
  logic [DW-1:0]        rem, dv;
  logic [QB-1:0]        q;
  logic [CNT_W-1:0]     cnt;
  logic                 neg, ovf;
  logic signed [SW-1:0] sx, sy;

  logic signed [AW-1:0] a1, a2, mul_a;
  logic signed [BW-1:0] b1, b2, mul_b;
  logic                 sub;
  logic signed [NW-1:0] acc_sum, rnd_sum, rnd_shift;
  logic signed [RW-1:0] rot_res;
  logic signed [AW-1:0] zs_calc;
  logic [NW-1:0]        mag;
  logic signed [SW-1:0] scr;
  logic                 slot_free;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || !out_stall;

  // operand pairs for each accumulate pass
  always_comb begin
    a1  = AW'(x);
    b1  = BW'(cos_y);
    a2  = AW'(z);
    b2  = BW'(sin_y);
    sub = 1'b0;
    case (op)
      OP_X_NY: begin
        a1 = AW'(y); b1 = BW'(cos_x); a2 = AW'(z); b2 = BW'(sin_x); sub = 1'b1;
      end
      OP_X_NZ: begin
        a1 = AW'(y); b1 = BW'(sin_x); a2 = AW'(z); b2 = BW'(cos_x);
      end
      OP_Y_NX: begin
        a1 = AW'(x); b1 = BW'(cos_y); a2 = AW'(z); b2 = BW'(sin_y);
      end
      OP_Y_NZ: begin
        a1 = AW'(z); b1 = BW'(cos_y); a2 = AW'(x); b2 = BW'(sin_y); sub = 1'b1;
      end
      OP_Z_NX: begin
        a1 = AW'(x); b1 = BW'(cos_z); a2 = AW'(y); b2 = BW'(sin_z); sub = 1'b1;
      end
      OP_Z_NY: begin
        a1 = AW'(x); b1 = BW'(sin_z); a2 = AW'(y); b2 = BW'(cos_z);
      end
      OP_PROJ_X: begin
        a1 = AW'(x); b1 = BW'(rpp_pkg::FOCAL);
        a2 = signed'(zs); b2 = signed'(BW'(center_x));
      end
      OP_PROJ_Y: begin
        a1 = AW'(y); b1 = BW'(rpp_pkg::FOCAL);
        a2 = signed'(zs); b2 = signed'(BW'(center_y));
      end
      default: ;
    endcase
    mul_a = (state == ST_MUL_A) ? a1 : a2;
    mul_b = (state == ST_MUL_A) ? b1 : b2;
  end

  always_comb begin
    acc_sum   = sub ? (acc - NW'(p)) : (acc + NW'(p));
    // round half up, floor shift
    rnd_sum   = acc_sum + ROUND_HALF;
    rnd_shift = rnd_sum >>> TRIG_FRAC_BITS;
    rot_res   = rnd_shift[RW-1:0];

    zs_calc = AW'(z) + AW'(FOCAL_Q);

    mag = acc[NW-1] ? NW'(-acc) : NW'(acc);

    if (ovf) begin
      scr = neg ? rpp_pkg::SCREEN_MIN : rpp_pkg::SCREEN_MAX;
    end else if (neg) begin
      scr = (q > QB'(32768)) ? rpp_pkg::SCREEN_MIN : signed'(SW'(-q));
    end else begin
      scr = (q > QB'(32767)) ? rpp_pkg::SCREEN_MAX : signed'(SW'(q));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_X_NY;
      out_valid <= 1'b0;
      last_x    <= '0;
      last_y    <= '0;
      cos_x     <= TRIG_ONE;
      sin_x     <= '0;
      cos_y     <= TRIG_ONE;
      sin_y     <= '0;
      cos_z     <= TRIG_ONE;
      sin_z     <= '0;
      center_x  <= 12'd450;
      center_y  <= 12'd300;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rpp_pkg::CFG_COS_X:    cos_x    <= cfg_data[TRIG_WIDTH-1:0];
          rpp_pkg::CFG_SIN_X:    sin_x    <= cfg_data[TRIG_WIDTH-1:0];
          rpp_pkg::CFG_COS_Y:    cos_y    <= cfg_data[TRIG_WIDTH-1:0];
          rpp_pkg::CFG_SIN_Y:    sin_y    <= cfg_data[TRIG_WIDTH-1:0];
          rpp_pkg::CFG_COS_Z:    cos_z    <= cfg_data[TRIG_WIDTH-1:0];
          rpp_pkg::CFG_SIN_Z:    sin_z    <= cfg_data[TRIG_WIDTH-1:0];
          rpp_pkg::CFG_CENTER_X: center_x <= cfg_data[rpp_pkg::CENTER_WIDTH-1:0];
          rpp_pkg::CFG_CENTER_Y: center_y <= cfg_data[rpp_pkg::CENTER_WIDTH-1:0];
          default: ;
        endcase
      end

      // drop the result word once taken, unless a new one loads now
      if (out_valid && !out_stall && !(state == ST_FINISH && !first)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            x     <= RW'(in_data.vx);
            y     <= RW'(in_data.vy);
            z     <= RW'(in_data.vz);
            first <= in_data.first_point;
            op    <= OP_X_NY;
            state <= ST_MUL_A;
          end
        end
        ST_MUL_A: begin
          p     <= mul_a * mul_b;
          state <= ST_MUL_B;
        end
        ST_MUL_B: begin
          acc   <= NW'(p);
          p     <= mul_a * mul_b;
          state <= ST_SUM;
        end
        ST_SUM: begin
          case (op)
            OP_X_NY: begin tmp <= rot_res; op <= OP_X_NZ; state <= ST_MUL_A; end
            OP_X_NZ: begin
              y <= tmp; z <= rot_res; op <= OP_Y_NX; state <= ST_MUL_A;
            end
            OP_Y_NX: begin tmp <= rot_res; op <= OP_Y_NZ; state <= ST_MUL_A; end
            OP_Y_NZ: begin
              x <= tmp; z <= rot_res; op <= OP_Z_NX; state <= ST_MUL_A;
            end
            OP_Z_NX: begin tmp <= rot_res; op <= OP_Z_NY; state <= ST_MUL_A; end
            OP_Z_NY: begin x <= tmp; y <= rot_res; state <= ST_ZS; end
            default: begin
              acc   <= acc_sum;
              state <= ST_DIV_PREP;
            end
          endcase
        end
        ST_ZS: begin
          // clamp a non-positive depth to one LSB
          if (zs_calc[AW-1] || zs_calc == '0) begin
            zs <= AW'(1);
          end else begin
            zs <= unsigned'(zs_calc);
          end
          op    <= OP_PROJ_X;
          state <= ST_MUL_A;
        end
        ST_DIV_PREP: begin
          neg   <= acc[NW-1];
          rem   <= DW'(mag);
          ovf   <= DW'(mag) >= (DW'(zs) << QB);
          dv    <= DW'(zs) << (QB - 1);
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (rem >= dv) begin
            rem <= rem - dv;
            q   <= {q[QB-2:0], 1'b1};
          end else begin
            q   <= {q[QB-2:0], 1'b0};
          end
          dv  <= dv >> 1;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(QB - 1)) begin
            state <= ST_DIV_DONE;
          end
        end
        ST_DIV_DONE: begin
          if (op == OP_PROJ_X) begin
            sx    <= scr;
            op    <= OP_PROJ_Y;
            state <= ST_MUL_A;
          end else begin
            sy    <= scr;
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // store the point; a later point holds until the result word slot is free
          if (first) begin
            last_x <= sx;
            last_y <= sy;
            state  <= ST_IDLE;
          end else if (slot_free) begin
            out_data.from_x <= last_x;
            out_data.from_y <= last_y;
            out_data.to_x   <= sx;
            out_data.to_y   <= sy;
            out_valid       <= 1'b1;
            last_x          <= sx;
            last_y          <= sy;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
